[design/l1pdf_pkg.sv]
// Shared constants and the Latin-1 to PDFDocEncoding mapping for the string escaper.
`default_nettype none

package l1pdf_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [POS_W-1:0]  pos_t;

    // Position of the output byte within one escape sequence
    localparam pos_t POS_LEAD = 2'd0;
    localparam pos_t POS_LAST = 2'd3;

    localparam byte_t CH_SPACE     = 8'h20;
    localparam byte_t CH_TILDE     = 8'h7E;
    localparam byte_t CH_LPAREN    = 8'h28;
    localparam byte_t CH_RPAREN    = 8'h29;
    localparam byte_t CH_HYPHEN    = 8'h2D;
    localparam byte_t CH_BACKSLASH = 8'h5C;
    localparam byte_t CH_NUL       = 8'h00;
    localparam byte_t CH_NBSP      = 8'hA0;
    localparam byte_t CH_SHY       = 8'hAD;

    // Upper five bits of an ASCII octal digit ('0' is 0x30)
    localparam logic [4:0] DIGIT_HI = 5'b00110;

    // Latin-1 0x80..0x9F to PDFDocEncoding
    localparam byte_t HIGH_CTRL_MAP [32] = '{
        8'hA0, 8'h57, 8'h77, 8'h20, 8'h20, 8'h59, 8'h79, 8'h20,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h83, 8'h92, 8'h8B, 8'h80,
        8'h8F, 8'h90, 8'h88, 8'h89, 8'h8D, 8'h8E, 8'h8C, 8'h85,
        8'h84, 8'h8A, 8'h96, 8'h9C, 8'h81, 8'h82, 8'h93, 8'h94
    };

    function automatic byte_t pdfdoc_map(input byte_t c);
        byte_t m;
        priority if (c < 8'h20) begin
            m = CH_SPACE;
        end else if (c < 8'h80) begin
            m = c;
        end else if (c < 8'hA0) begin
            m = HIGH_CTRL_MAP[c[4:0]];
        end else if (c == CH_NBSP) begin
            m = CH_SPACE;
        end else if (c == CH_SHY) begin
            m = CH_HYPHEN;
        end else begin
            m = c;
        end
        return m;
    endfunction

    // True where the mapped byte must go out as a backslash and three octal digits
    function automatic logic needs_escape(input byte_t m);
        return !((m >= CH_SPACE) && (m <= CH_TILDE) && (m != CH_LPAREN) && (m != CH_RPAREN));
    endfunction

endpackage

`default_nettype wire

[design/latin1_to_pdf_string_escape.sv]
// Top level of the Latin-1 to PDFDocEncoding string escaper.
`default_nettype none

// Latin-1 to PDFDocEncoding string escaper. Each input word is one Latin-1
// character; it is looked up in a 256-entry mapping ROM with a registered
// read, and the mapped byte leaves as one output word if it is
// printable (space to tilde) and not a parenthesis, or as four words
// (backslash and three octal digits, most significant first) otherwise.
// A zero input word closes the string and gives a single zero word with
// tuser set. tlast marks the final output word caused by each input word.
// Rate: one input word per cycle for bytes that pass through, while the
// output is not stalled; an escaped byte holds the ROM output register
// while its four output words go out, so the expander sets the rate for
// escaped bytes. Input reaches the first output word through the ROM read
// register, then the output register. A new word is taken in the cycle
// the last output word of the previous one moves to the output register.
module latin1_to_pdf_string_escape (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] byte_in
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_out
    output logic       m_tlast,   // last_of_run
    output logic       m_tuser    // [0] end_of_string
);

    // ROM output stage: mapped byte plus the expander position
    logic                 rd_valid_reg;
    l1pdf_pkg::byte_t     rom_q_reg;
    logic                 zero_reg;
    l1pdf_pkg::pos_t      pos_reg;
    l1pdf_pkg::pos_t      pos_next;

    // Output register
    logic                 m_tvalid_reg;
    l1pdf_pkg::byte_t     m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;

    logic                 out_free;
    logic                 esc;
    logic                 cur_last;
    logic                 rd_take;
    logic                 s_accept;
    l1pdf_pkg::byte_t     cur_byte;

    assign out_free = !m_tvalid_reg || m_tready;
    assign esc      = l1pdf_pkg::needs_escape(rom_q_reg);
    assign cur_last = zero_reg || !esc || (pos_reg == l1pdf_pkg::POS_LAST);
    // ROM stage frees up when empty or when its final word goes out
    assign rd_take  = !rd_valid_reg || (out_free && cur_last);
    assign s_tready = rd_take;
    assign s_accept = s_tvalid && rd_take;

    // Byte selected for the current expander position
    always_comb begin
        if (zero_reg) begin
            cur_byte = l1pdf_pkg::CH_NUL;
        end else if (!esc) begin
            cur_byte = rom_q_reg;
        end else begin
            unique case (pos_reg)
                2'd0:    cur_byte = l1pdf_pkg::CH_BACKSLASH;
                2'd1:    cur_byte = {l1pdf_pkg::DIGIT_HI, 1'b0, rom_q_reg[7:6]};
                2'd2:    cur_byte = {l1pdf_pkg::DIGIT_HI, rom_q_reg[5:3]};
                default: cur_byte = {l1pdf_pkg::DIGIT_HI, rom_q_reg[2:0]};
            endcase
        end
    end

    // Note: cur_byte for position 1 only carries two digit bits (value 0..3)
    always_comb begin
        pos_next = pos_reg;
        if (s_accept) begin
            pos_next = l1pdf_pkg::POS_LEAD;
        end else if (rd_valid_reg && out_free && !cur_last) begin
            pos_next = pos_reg + 2'd1;
        end
    end

    // Mapping ROM with registered read; holds while the expander works
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rom_q_reg <= l1pdf_pkg::pdfdoc_map(s_tdata);
            zero_reg  <= (s_tdata == l1pdf_pkg::CH_NUL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            pos_reg      <= l1pdf_pkg::POS_LEAD;
        end else begin
            pos_reg <= pos_next;
            if (rd_take) begin
                rd_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && rd_valid_reg) begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= cur_last;
            m_tuser_reg <= zero_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // The terminator word is a zero byte that closes its run
    a_eos_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == l1pdf_pkg::CH_NUL && m_tlast))
        else $error("terminator word malformed");

    // The expander only steps past the lead position for an escaped byte
    a_pos_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_valid_reg && pos_reg != l1pdf_pkg::POS_LEAD) |-> (esc && !zero_reg))
        else $error("expander advanced on a plain byte");

    // A word that is not the last of its run is always followed by more of the same run
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("escape run broken off");
`endif

endmodule

`default_nettype wire
